// File: hw/rtl/wtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtw_pkg: shared types and constants of the weekly time window block
// Request and response payloads, parser phases, character codes and the
// day range mask helper.
// ----------------------------------------------------------------------------
package wtw_pkg;

   localparam logic FUNC_CHAR  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic KIND_PARSE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam logic [6:0] CHAR_END   = 7'h00;
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_ONE   = 7'h31;
   localparam logic [6:0] CHAR_SEVEN = 7'h37;
   localparam logic [6:0] CHAR_NINE  = 7'h39;
   localparam logic [6:0] CHAR_DASH  = 7'h2D;
   localparam logic [6:0] CHAR_COMMA = 7'h2C;
   localparam logic [6:0] CHAR_TILDE = 7'h7E;

   localparam logic [6:0]  LAST_HOUR        = 7'd23;
   localparam logic [3:0]  MAX_MINUTE_TENS  = 4'd5;
   localparam logic [10:0] MINUTES_PER_HOUR = 11'd60;
   localparam logic [10:0] TENS             = 11'd10;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_FIRST,
      PH_SH2,
      PH_SM1,
      PH_SM2,
      PH_DASH,
      PH_EH1,
      PH_EH2,
      PH_EM1,
      PH_EM2,
      PH_TAIL,
      PH_DDIGIT,
      PH_DAFTER,
      PH_DRANGE,
      PH_DSEP,
      PH_FAIL
   } phase_type;

   typedef struct packed {
      logic       func;
      logic [6:0] char_code;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [2:0] weekday;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic        parse_ok;
      logic        window_valid;
      logic [10:0] start_minute;
      logic [10:0] end_minute;
      logic        days_valid;
      logic [6:0]  day_set;
      logic        active;
   } rsp_payload_type;

   // Mask of days first..last, Monday in bit 0.
   function automatic logic [6:0] day_span(input logic [2:0] first, input logic [2:0] last);
      logic [6:0] mask;
      mask = '0;
      for (int i = 0; i < 7; i++) begin
         if ((3'(i + 1) >= first) && (3'(i + 1) <= last)) begin
            mask[i] = 1'b1;
         end
      end
      return mask;
   endfunction

endpackage

// File: hw/rtl/wtw_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtw_stream_if: valid/ready channel
// Carries one payload per handshake; source drives valid and payload, sink
// drives ready.
// ----------------------------------------------------------------------------
interface wtw_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/weekly_time_window_parser_matcher.sv
`timescale 1ns / 1ps
// Path: an accepted request is held in the request register, and its response is then loaded
// into the response register. Characters other than the terminator give no response.
// Throughput: one request per cycle; the request register stalls only while a response
// waits in the response register and the request in front of it would produce another.
// Reset: synchronous; empties both registers, clears the stored schedule, parser idle.
// ----------------------------------------------------------------------------
// weekly_time_window_parser_matcher: schedule string parser and matcher
// Parses "HHMM-HHMM[~days]" or a day list one character per request and
// answers hour/minute/weekday activity queries against the stored schedule.
// ----------------------------------------------------------------------------
module weekly_time_window_parser_matcher
   import wtw_pkg::*;
(
   input logic          clock,
   input logic          reset,
   wtw_stream_if.sink   req_if,
   wtw_stream_if.source rsp_if
);

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   phase_type   phase_ff, phase_in;
   logic [3:0]  hold_ff, hold_in;
   logic [10:0] accum_ff, accum_in;
   logic [2:0]  rfirst_ff, rfirst_in;
   logic [6:0]  pending_ff, pending_in;
   logic        win_set_ff, win_set_in;
   logic [10:0] win_start_ff, win_start_in;
   logic [10:0] win_end_ff, win_end_in;
   logic        days_set_ff, days_set_in;
   logic [6:0]  day_bits_ff, day_bits_in;

   logic        produces;
   logic        step;
   logic [6:0]  c;
   logic [6:0]  dfull;
   logic [3:0]  dval;
   logic [2:0]  dday;
   logic        is_dig;
   logic        is_day;
   logic [6:0]  hh;
   logic [10:0] hh_minutes;
   logic [10:0] sum_minutes;
   logic [10:0] now_minute;
   logic [7:0]  day_shift;
   logic        act;
   logic        ok;

   assign c        = in_data_ff.char_code;
   assign produces = (in_data_ff.func == FUNC_QUERY) || (c == CHAR_END);
   assign step     = in_valid_ff && (!produces || !rsp_valid_ff || rsp_if.ready);

   assign req_if.ready   = !in_valid_ff || step;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   assign dfull       = c - CHAR_ZERO;
   assign dval        = dfull[3:0];
   assign dday        = dfull[2:0];
   assign is_dig      = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   assign is_day      = (c >= CHAR_ONE) && (c <= CHAR_SEVEN);
   assign hh          = 7'(hold_ff) * 7'd10 + 7'(dval);
   assign hh_minutes  = 11'(hh) * MINUTES_PER_HOUR;
   assign sum_minutes = accum_ff + 11'(hold_ff) * TENS + 11'(dval);
   assign now_minute  = 11'(in_data_ff.hour) * MINUTES_PER_HOUR + 11'(in_data_ff.minute);
   assign day_shift   = {day_bits_ff, 1'b0} >> in_data_ff.weekday;

   always_comb begin
      act = 1'b1;
      if (days_set_ff && !day_shift[0]) begin
         act = 1'b0;
      end
      if (act && win_set_ff) begin
         if (win_start_ff < win_end_ff) begin
            if ((now_minute < win_start_ff) || (now_minute >= win_end_ff)) begin
               act = 1'b0;
            end
         end else if (win_start_ff > win_end_ff) begin
            if ((now_minute < win_start_ff) && (now_minute >= win_end_ff)) begin
               act = 1'b0;
            end
         end
      end
   end

   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      accum_in     = accum_ff;
      rfirst_in    = rfirst_ff;
      pending_in   = pending_ff;
      win_set_in   = win_set_ff;
      win_start_in = win_start_ff;
      win_end_in   = win_end_ff;
      days_set_in  = days_set_ff;
      day_bits_in  = day_bits_ff;
      ok           = 1'b0;

      if (step && (in_data_ff.func == FUNC_CHAR)) begin
         if (phase_ff == PH_IDLE) begin
            win_set_in   = 1'b0;
            win_start_in = '0;
            win_end_in   = '0;
            days_set_in  = 1'b0;
            day_bits_in  = '0;
            pending_in   = '0;
            accum_in     = '0;
            rfirst_in    = '0;
            hold_in      = '0;
            ok           = 1'b1;
            if (c != CHAR_END) begin
               if (is_dig) begin
                  hold_in  = dval;
                  phase_in = PH_FIRST;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end else if (c != CHAR_END) begin
            phase_in = PH_FAIL;
            unique case (phase_ff)
               PH_FIRST: begin
                  if (is_dig) begin
                     if (hh <= LAST_HOUR) begin
                        accum_in = hh_minutes;
                        phase_in = PH_SM1;
                     end
                  end else if ((hold_ff >= 4'd1) && (hold_ff <= 4'd7)) begin
                     if (c == CHAR_DASH) begin
                        rfirst_in = hold_ff[2:0];
                        phase_in  = PH_DRANGE;
                     end else if (c == CHAR_COMMA) begin
                        pending_in = pending_ff | day_span(hold_ff[2:0], hold_ff[2:0]);
                        phase_in   = PH_DDIGIT;
                     end
                  end
               end
               PH_SM1, PH_EM1: begin
                  if (is_dig && (dval <= MAX_MINUTE_TENS)) begin
                     hold_in  = dval;
                     phase_in = (phase_ff == PH_SM1) ? PH_SM2 : PH_EM2;
                  end
               end
               PH_SM2: begin
                  if (is_dig) begin
                     accum_in = sum_minutes;
                     phase_in = PH_DASH;
                  end
               end
               PH_DASH: begin
                  if (c == CHAR_DASH) begin
                     win_start_in = accum_ff;
                     phase_in     = PH_EH1;
                  end
               end
               PH_EH1: begin
                  if (is_dig) begin
                     hold_in  = dval;
                     phase_in = PH_EH2;
                  end
               end
               PH_EH2: begin
                  if (is_dig && (hh <= LAST_HOUR)) begin
                     accum_in = hh_minutes;
                     phase_in = PH_EM1;
                  end
               end
               PH_EM2: begin
                  if (is_dig) begin
                     win_end_in = sum_minutes;
                     win_set_in = 1'b1;
                     phase_in   = PH_TAIL;
                  end
               end
               PH_TAIL: begin
                  if (c == CHAR_TILDE) begin
                     phase_in = PH_DDIGIT;
                  end
               end
               PH_DDIGIT: begin
                  if (is_day) begin
                     rfirst_in = dday;
                     phase_in  = PH_DAFTER;
                  end
               end
               PH_DAFTER: begin
                  if (c == CHAR_DASH) begin
                     phase_in = PH_DRANGE;
                  end else if (c == CHAR_COMMA) begin
                     pending_in = pending_ff | day_span(rfirst_ff, rfirst_ff);
                     phase_in   = PH_DDIGIT;
                  end
               end
               PH_DRANGE: begin
                  if (is_day && (dday >= rfirst_ff)) begin
                     pending_in = pending_ff | day_span(rfirst_ff, dday);
                     phase_in   = PH_DSEP;
                  end
               end
               PH_DSEP: begin
                  if (c == CHAR_COMMA) begin
                     phase_in = PH_DDIGIT;
                  end
               end
               default: begin
                  phase_in = PH_FAIL;
               end
            endcase
         end else begin
            unique case (phase_ff)
               PH_FIRST: begin
                  if ((hold_ff >= 4'd1) && (hold_ff <= 4'd7)) begin
                     pending_in = pending_ff | day_span(hold_ff[2:0], hold_ff[2:0]);
                     ok         = 1'b1;
                  end
               end
               PH_DAFTER: begin
                  pending_in = pending_ff | day_span(rfirst_ff, rfirst_ff);
                  ok         = 1'b1;
               end
               PH_DDIGIT: ok = (pending_ff != '0);
               PH_TAIL, PH_DSEP: ok = 1'b1;
               default: ok = 1'b0;
            endcase
            if (ok && (pending_in != '0)) begin
               days_set_in = 1'b1;
               day_bits_in = pending_in;
            end
            phase_in = PH_IDLE;
         end
      end
   end

   always_comb begin
      rsp_data_in.kind         = (in_data_ff.func == FUNC_QUERY) ? KIND_QUERY : KIND_PARSE;
      rsp_data_in.parse_ok     = (in_data_ff.func == FUNC_CHAR) && ok;
      rsp_data_in.window_valid = win_set_in;
      rsp_data_in.start_minute = win_set_in ? win_start_in : '0;
      rsp_data_in.end_minute   = win_set_in ? win_end_in : '0;
      rsp_data_in.days_valid   = days_set_in;
      rsp_data_in.day_set      = days_set_in ? day_bits_in : '0;
      rsp_data_in.active       = (in_data_ff.func == FUNC_QUERY) && act;
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_if.ready) begin
         in_valid_in = req_if.valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step && produces) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.ready && req_if.valid) begin
         in_data_ff <= req_if.payload;
      end
      if (step && produces) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         hold_ff      <= '0;
         accum_ff     <= '0;
         rfirst_ff    <= '0;
         pending_ff   <= '0;
         win_set_ff   <= 1'b0;
         win_start_ff <= '0;
         win_end_ff   <= '0;
         days_set_ff  <= 1'b0;
         day_bits_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         accum_ff     <= accum_in;
         rfirst_ff    <= rfirst_in;
         pending_ff   <= pending_in;
         win_set_ff   <= win_set_in;
         win_start_ff <= win_start_in;
         win_end_ff   <= win_end_in;
         days_set_ff  <= days_set_in;
         day_bits_ff  <= day_bits_in;
      end
   end

`ifndef SYNTHESIS
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (step && produces) |=> rsp_valid_ff)
      else $error("response register not loaded after a producing request");

   a_terminator_idles: assert property (@(posedge clock) disable iff (reset)
      (step && (in_data_ff.func == FUNC_CHAR) && (c == CHAR_END)) |=> (phase_ff == PH_IDLE))
      else $error("parser not idle after terminator");

   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.parse_ok && rsp_data_ff.active))
      else $error("parse_ok and active both set in one response");

   a_empty_window: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.window_valid) |->
         ((rsp_data_ff.start_minute == '0) && (rsp_data_ff.end_minute == '0)))
      else $error("window bounds shown without a stored window");

   a_empty_days: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.days_valid) |-> (rsp_data_ff.day_set == '0))
      else $error("day set shown without a stored day set");
`endif

endmodule
